// File: rtl/tbpm_pkg.sv
package tbpm_pkg;

    // Quantization modes held in the configuration register. Code 3 is unused.
    typedef enum logic [1:0] {
        MODE_BINARY    = 2'd0,
        MODE_TERN_ACT  = 2'd1,
        MODE_TERN_BOTH = 2'd2
    } quant_mode_t;

    localparam int LANE_BITS   = 8;
    localparam int LANE_CNT_W  = $clog2(LANE_BITS + 1);
    localparam int LANE_DIFF_W = LANE_CNT_W + 1;

    localparam int SUM_W       = 20;
    localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

    typedef logic signed [LANE_DIFF_W-1:0] lane_diff_t;
    typedef logic signed [SUM_W-1:0]       conv_sum_t;

    // Side information that travels with a request through the lane stage.
    typedef struct packed {
        logic outside;
        logic last;
    } tap_ctrl_t;

endpackage

// File: rtl/tbpm_lane.sv
module tbpm_lane (
    input  logic [1:0]                     mode,
    input  logic [tbpm_pkg::LANE_BITS-1:0] pos,
    input  logic [tbpm_pkg::LANE_BITS-1:0] neg,
    input  logic [tbpm_pkg::LANE_BITS-1:0] wa,
    input  logic [tbpm_pkg::LANE_BITS-1:0] wb,
    input  logic [tbpm_pkg::LANE_BITS-1:0] mask,
    output tbpm_pkg::lane_diff_t           diff
);
    import tbpm_pkg::*;

    logic [LANE_BITS-1:0]  plus_bits;
    logic [LANE_BITS-1:0]  minus_bits;
    logic [LANE_CNT_W-1:0] plus_cnt;
    logic [LANE_CNT_W-1:0] minus_cnt;

    // Classify each channel product as +1, -1 or zero.
    always_comb begin
        case (mode)
            MODE_BINARY: begin
                minus_bits = (pos ^ wa) & mask;
                plus_bits  = ~(pos ^ wa) & mask;
            end
            MODE_TERN_ACT: begin
                minus_bits = ((pos & ~wa) | (neg & wa)) & mask;
                plus_bits  = ((pos & wa) | (neg & ~wa)) & mask;
            end
            MODE_TERN_BOTH: begin
                minus_bits = ((pos & wa) | (neg & wb)) & mask;
                plus_bits  = ((pos & wb) | (neg & wa)) & mask;
            end
            default: begin
                minus_bits = '0;
                plus_bits  = '0;
            end
        endcase
    end

    always_comb begin
        plus_cnt  = '0;
        minus_cnt = '0;
        for (int i = 0; i < LANE_BITS; i++) begin
            plus_cnt  = plus_cnt + LANE_CNT_W'(plus_bits[i]);
            minus_cnt = minus_cnt + LANE_CNT_W'(minus_bits[i]);
        end
    end

    assign diff = $signed({1'b0, plus_cnt}) - $signed({1'b0, minus_cnt});

endmodule

// File: rtl/tbpm_merge.sv
module tbpm_merge #(
    parameter int LANES = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  tbpm_pkg::tap_ctrl_t  ctrl,
    input  tbpm_pkg::lane_diff_t diff [LANES],
    input  logic                 out_take,
    output logic                 out_valid,
    output tbpm_pkg::conv_sum_t  out_sum
);
    import tbpm_pkg::*;

    localparam int TAP_W = $clog2(LANES * LANE_BITS + 1) + 1;

    logic signed [TAP_W-1:0] tap_sum;
    logic signed [SUM_W:0]   wide_sum;
    conv_sum_t               sat_sum;

    conv_sum_t acc_reg;
    conv_sum_t acc_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    conv_sum_t out_sum_reg;
    conv_sum_t out_sum_next;

    // Merge the lane counts into the tap value.
    always_comb begin
        tap_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            tap_sum = tap_sum + TAP_W'(diff[l]);
        end
    end

    // The tap value is far narrower than the sum, so one extra bit flags overflow.
    always_comb begin
        if (ctrl.outside) begin
            wide_sum = (SUM_W + 1)'(acc_reg);
        end else begin
            wide_sum = (SUM_W + 1)'(acc_reg) + (SUM_W + 1)'(tap_sum);
        end
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            sat_sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                      : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            sat_sum = wide_sum[SUM_W-1:0];
        end
    end

    always_comb begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_sum_next   = out_sum_reg;
        if (advance) begin
            if (ctrl.last) begin
                acc_next       = '0;
                out_valid_next = 1'b1;
                out_sum_next   = sat_sum;
            end else begin
                acc_next = sat_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
        out_sum_reg <= out_sum_next;
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

// File: rtl/ternary_binary_popcount_mac.sv
// Path: a result appears on m_tdata once the request carrying last_tap has
// passed the lane stage register and then the merge stage output register.
// Throughput: one request per cycle, sustained while results are taken; the
// input stalls only when a finished sum is still waiting on the output.
// Reset (aresetn low, synchronous): clears the accumulator, the pipeline valid
// flags and quant_mode, which returns to binary mode.
module ternary_binary_popcount_mac #(
    parameter int WORD_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,

    // Configuration: quant_mode, written when cfg_wr_en is high.
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,

    // Request channel.
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata, from bit 0 up: act_plane_pos, act_plane_neg, weight_plane_a,
    // weight_plane_b, channels_in_word, then zero fill to a whole byte.
    input  logic [((4 * WORD_BITS + $clog2(WORD_BITS + 1) + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser, from bit 0 up: tap_outside.
    input  logic [0:0] s_tuser,
    // s_tlast: last_tap.
    input  logic       s_tlast,

    // Result channel.
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata, from bit 0 up: conv_sum (signed), then zero fill.
    output logic [tbpm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tbpm_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int LANES = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
    localparam int PAD_W = LANES * LANE_BITS;

    // The user must change the quantization mode only while the block is idle;
    // the block does not enforce this. The lanes read it directly.
    logic [1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BINARY;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Unpack the request. Words are widened to a whole number of lanes; the
    // extra bits are masked away because they lie above the channel count.
    logic [PAD_W-1:0] act_pos;
    logic [PAD_W-1:0] act_neg;
    logic [PAD_W-1:0] wgt_a;
    logic [PAD_W-1:0] wgt_b;
    logic [CNT_W-1:0] chan_cnt;
    logic [CNT_W-1:0] chan_clamp;
    logic [PAD_W-1:0] chan_mask;

    assign act_pos  = PAD_W'(s_tdata[0 +: WORD_BITS]);
    assign act_neg  = PAD_W'(s_tdata[WORD_BITS +: WORD_BITS]);
    assign wgt_a    = PAD_W'(s_tdata[2 * WORD_BITS +: WORD_BITS]);
    assign wgt_b    = PAD_W'(s_tdata[3 * WORD_BITS +: WORD_BITS]);
    assign chan_cnt = s_tdata[4 * WORD_BITS +: CNT_W];

    // A channel count beyond the word is taken as the full word.
    assign chan_clamp = (chan_cnt > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : chan_cnt;

    always_comb begin
        for (int g = 0; g < PAD_W; g++) begin
            chan_mask[g] = (g < int'(chan_clamp));
        end
    end

    // Each lane counts +1 and -1 products over one byte of channels.
    lane_diff_t lane_diff [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        tbpm_lane u_lane (
            .mode (mode_reg),
            .pos  (act_pos[l * LANE_BITS +: LANE_BITS]),
            .neg  (act_neg[l * LANE_BITS +: LANE_BITS]),
            .wa   (wgt_a[l * LANE_BITS +: LANE_BITS]),
            .wb   (wgt_b[l * LANE_BITS +: LANE_BITS]),
            .mask (chan_mask[l * LANE_BITS +: LANE_BITS]),
            .diff (lane_diff[l])
        );
    end

    // Lane stage register. An ordinary tap always moves on into the
    // accumulator; a last tap waits only while the previous sum is unclaimed.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    tap_ctrl_t  s1_ctrl_reg;
    lane_diff_t s1_diff_reg [LANES];
    logic       s1_advance;
    logic       s_accept;
    logic       out_valid;
    conv_sum_t  out_sum;

    assign s1_advance = s1_valid_reg && (!s1_ctrl_reg.last || !out_valid || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
        if (s_accept) begin
            s1_ctrl_reg.outside <= s_tuser[0];
            s1_ctrl_reg.last    <= s_tlast;
            s1_diff_reg         <= lane_diff;
        end
    end

    // Merge stage: adds the lane counts, accumulates with saturation and holds
    // the finished sum in the output register.
    tbpm_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s1_advance),
        .ctrl      (s1_ctrl_reg),
        .diff      (s1_diff_reg),
        .out_take  (m_tready),
        .out_valid (out_valid),
        .out_sum   (out_sum)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_TDATA_W'($unsigned(out_sum));

endmodule

// File: rtl/tbpm_checker.sv
module tbpm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tbpm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tbpm_pkg::*;

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A fresh result must be preceded by a last request being taken.
    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a matching last request");

    // While the output is drained the input is never held off.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // A stalled result holds its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind ternary_binary_popcount_mac tbpm_checker u_tbpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
